>>> rtl/core/wireless_client_tracker_top_macros.svh
// Assertion macros for the tracker RTL.
// Needs nothing; included inside module bodies.
`ifndef WIRELESS_CLIENT_TRACKER_TOP_MACROS_SVH
`define WIRELESS_CLIENT_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define WCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wct assertion failed");

// next-cycle implication
`define WCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wct assertion failed");

`endif

>>> rtl/core/wct_pkg.sv
// Package for the wireless client tracker: codes, constants, queue beat type.
// No dependencies.
`timescale 1ns / 1ps
package wct_pkg;

	localparam int WCT_CLIENT_SLOTS = 20;
	localparam int PADDR_W = 4;
	localparam logic [PADDR_W-1:0] ADDR_AP_ADDR = 4'h0;
	localparam logic [PADDR_W-1:0] ADDR_MAX_LEN = 4'h8;

	localparam logic [11:0] MAX_LEN_RESET = 12'd2324;
	localparam logic [7:0] STRENGTH_RESET = 8'h9D;  // -99 dBm
	localparam logic [15:0] PACKETS_MAX = 16'hFFFF;
	localparam int GROUP_BIT = 40;

	typedef enum logic [2:0] {
		ST_TOO_LONG  = 3'd0,
		ST_FOREIGN   = 3'd1,
		ST_UPDATED   = 3'd2,
		ST_ADDED     = 3'd3,
		ST_EVICTED   = 3'd4,
		ST_AP_GROUP  = 3'd5,
		ST_READ      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CLS_READ,
		CLS_LONG,
		CLS_FOREIGN,
		CLS_AP_GROUP,
		CLS_TRACK_RX,
		CLS_TRACK_TX
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [47:0] key;
		logic [7:0]  key_str;
		logic [7:0]  ap_str;
		logic [31:0] now;
		logic [4:0]  rslot;
	} item_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [7:0]  strength;
		logic [15:0] packets;
		logic [31:0] last_seen;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_FETCH,
		S_COMMIT,
		S_RDWAIT
	} bstate_t;

endpackage

>>> rtl/core/wct_front.sv
// Front end: configuration registers and classification of each accepted beat.
// Depends on wct_pkg.
`timescale 1ns / 1ps
module wct_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wct_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	input  logic                        take,
	input  logic                        req_type,
	input  logic [47:0]                 transmitter_addr,
	input  logic [47:0]                 receiver_addr,
	input  logic [7:0]                  signal_strength,
	input  logic [11:0]                 frame_length,
	input  logic [31:0]                 now_ms,
	input  logic [4:0]                  read_slot,
	output logic                        push,
	output wct_pkg::item_t              item
);
	import wct_pkg::*;

	logic [47:0] ap_addr_q;
	logic [11:0] max_len_q;
	logic        wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_addr_q <= '0;
			max_len_q <= MAX_LEN_RESET;
		end else if (wr_en) begin
			if (paddr == ADDR_AP_ADDR)
				ap_addr_q <= pwdata[47:0];
			if (paddr == ADDR_MAX_LEN)
				max_len_q <= pwdata[11:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_AP_ADDR)
			prdata = {16'd0, ap_addr_q};
		else if (paddr == ADDR_MAX_LEN)
			prdata = {52'd0, max_len_q};
	end

	assign push = take;

	always_comb begin
		item.key     = transmitter_addr;
		item.key_str = signal_strength;
		item.ap_str  = signal_strength;
		item.now     = now_ms;
		item.rslot   = read_slot;
		if (req_type)
			item.cls = CLS_READ;
		else if (frame_length > max_len_q)
			item.cls = CLS_LONG;
		else if (transmitter_addr != ap_addr_q && receiver_addr != ap_addr_q)
			item.cls = CLS_FOREIGN;
		else if (transmitter_addr == ap_addr_q) begin
			item.key     = receiver_addr;
			item.key_str = STRENGTH_RESET;
			item.cls     = receiver_addr[GROUP_BIT] ? CLS_AP_GROUP : CLS_TRACK_RX;
		end else
			item.cls = CLS_TRACK_TX;
	end

endmodule

>>> rtl/core/wct_fifo.sv
// Two-entry queue between the classifier and the table engine.
// Depends on wct_pkg.
`timescale 1ns / 1ps
module wct_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wct_pkg::item_t wdata,
	input  logic           pop,
	output wct_pkg::item_t rdata,
	output logic           full,
	output logic           empty
);
	import wct_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wp_q <= ~wp_q;
			if (pop && !empty)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

>>> rtl/core/wct_back.sv
// Table engine: walks the station table for match, free and oldest slot,
// then updates the entry and drives the result beat. Depends on wct_pkg.
`timescale 1ns / 1ps
module wct_back #(
	parameter int CLIENT_SLOTS = wct_pkg::WCT_CLIENT_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  wct_pkg::item_t q_head,
	output logic           q_pop,
	output logic           done,
	output logic [2:0]     status,
	output logic [4:0]     slot,
	output logic [4:0]     client_count,
	output logic [7:0]     ap_strength,
	output logic           entry_valid,
	output logic [47:0]    entry_addr,
	output logic [7:0]     entry_strength,
	output logic [15:0]    entry_packets,
	output logic [31:0]    entry_last_seen,
	output logic [31:0]    accepted_total
);
	import wct_pkg::*;
	`include "wireless_client_tracker_top_macros.svh"

	localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int CW = $clog2(CLIENT_SLOTS + 1);
	localparam logic [SW-1:0] LAST = SW'(CLIENT_SLOTS - 1);

	entry_t  mem [CLIENT_SLOTS];
	entry_t  rdata_q;
	logic [SW-1:0] rd_addr;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	entry_t        wr_data;

	bstate_t state_q, state_d;
	item_t   cur_q;
	logic [CLIENT_SLOTS-1:0] valid_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    ap_q;
	logic [31:0]   acc_q;

	logic [SW-1:0] scan_q;
	logic          chk_vld_s1;
	logic [SW-1:0] chk_idx_s1;
	logic          hit_q, free_q;
	logic [SW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0]   old_ts_q;

	logic          done_q;
	status_t       status_q;
	logic [SW-1:0] slot_q;
	logic [4:0]    rslot_out_q;
	logic          use_rslot_q;
	logic          ev_q;
	entry_t        eo_q;

	logic          rs_in;
	logic [SW-1:0] rs_idx;
	logic [SW-1:0] tgt;
	logic [15:0]   new_pk;
	status_t       trk_st;

	assign rs_in  = 32'(cur_q.rslot) < CLIENT_SLOTS;
	assign rs_idx = SW'(cur_q.rslot);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_addr = scan_q;
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (cur_q.cls)
					CLS_READ: begin
						rd_addr = rs_in ? rs_idx : '0;
						state_d = S_RDWAIT;
					end
					CLS_TRACK_RX, CLS_TRACK_TX: state_d = S_SCAN;
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				if (scan_q == LAST)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_FETCH;
			S_FETCH: begin
				rd_addr = hit_idx_q;
				state_d = S_COMMIT;
			end
			S_COMMIT: state_d = S_IDLE;
			S_RDWAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (hit_q) begin
			tgt    = hit_idx_q;
			trk_st = ST_UPDATED;
			new_pk = (rdata_q.packets == PACKETS_MAX) ? PACKETS_MAX : rdata_q.packets + 16'd1;
		end else if (free_q) begin
			tgt    = free_idx_q;
			trk_st = ST_ADDED;
			new_pk = 16'd1;
		end else begin
			tgt    = old_idx_q;
			trk_st = ST_EVICTED;
			new_pk = 16'd1;
		end
		wr_en   = state_q == S_COMMIT;
		wr_addr = tgt;
		wr_data = '{addr: cur_q.key, strength: cur_q.key_str, packets: new_pk,
			last_seen: cur_q.now};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			cnt_q      <= '0;
			ap_q       <= STRENGTH_RESET;
			acc_q      <= '0;
			done_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			chk_vld_s1 <= state_q == S_SCAN;
			if (state_q == S_DISPATCH && cur_q.cls != CLS_READ
					&& cur_q.cls != CLS_TRACK_RX && cur_q.cls != CLS_TRACK_TX) begin
				done_q <= 1'b1;
				if (cur_q.cls == CLS_AP_GROUP)
					ap_q <= cur_q.ap_str;
			end
			if (state_q == S_RDWAIT)
				done_q <= 1'b1;
			if (state_q == S_COMMIT) begin
				done_q       <= 1'b1;
				acc_q        <= acc_q + 32'd1;
				valid_q[tgt] <= 1'b1;
				if (!hit_q && free_q)
					cnt_q <= cnt_q + CW'(1);
				if (cur_q.cls == CLS_TRACK_RX)
					ap_q <= cur_q.ap_str;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE)
			cur_q <= q_head;
		chk_idx_s1 <= scan_q;
		if (state_q == S_DISPATCH) begin
			scan_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (state_q == S_SCAN && scan_q != LAST)
			scan_q <= scan_q + SW'(1);
		if (chk_vld_s1) begin
			if (valid_q[chk_idx_s1] && rdata_q.addr == cur_q.key && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= chk_idx_s1;
			end
			if (!valid_q[chk_idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
			if (chk_idx_s1 == '0 || rdata_q.last_seen < old_ts_q) begin
				old_idx_q <= chk_idx_s1;
				old_ts_q  <= rdata_q.last_seen;
			end
		end
		case (state_q)
			S_DISPATCH: begin
				use_rslot_q <= 1'b0;
				ev_q        <= 1'b0;
				slot_q      <= '0;
				eo_q        <= '0;
				rslot_out_q <= cur_q.rslot;
				case (cur_q.cls)
					CLS_LONG:     status_q <= ST_TOO_LONG;
					CLS_FOREIGN:  status_q <= ST_FOREIGN;
					CLS_AP_GROUP: status_q <= ST_AP_GROUP;
					default:      status_q <= ST_READ;
				endcase
			end
			S_RDWAIT: begin
				use_rslot_q <= 1'b1;
				status_q    <= ST_READ;
				ev_q        <= rs_in && valid_q[rs_idx];
				eo_q        <= (rs_in && valid_q[rs_idx]) ? rdata_q : '0;
			end
			S_COMMIT: begin
				status_q <= trk_st;
				slot_q   <= tgt;
				ev_q     <= 1'b1;
				eo_q     <= wr_data;
			end
			default: ;
		endcase
	end

	assign done            = done_q;
	assign status          = status_q;
	assign slot            = use_rslot_q ? rslot_out_q : 5'(slot_q);
	assign client_count    = 5'(cnt_q);
	assign ap_strength     = ap_q;
	assign entry_valid     = ev_q;
	assign entry_addr      = eo_q.addr;
	assign entry_strength  = eo_q.strength;
	assign entry_packets   = eo_q.packets;
	assign entry_last_seen = eo_q.last_seen;
	assign accepted_total  = acc_q;

	`WCT_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`WCT_ASSERT_IMP(a_cnt_match, clk, arst_n, 1'b1, 32'(cnt_q) == $countones(valid_q))
	`WCT_ASSERT_NXT(a_commit_done, clk, arst_n, state_q == S_COMMIT, done_q && ev_q)

endmodule

>>> rtl/core/wireless_client_tracker_top.sv
// Wireless client tracker top level: LRU station table for one access point.
// Depends on wct_pkg, wct_front, wct_fifo, wct_back.
//
// Use: pulse start with the item fields while busy is low; the beat is taken
// at that edge. Frame events (req_type 0) are filtered against the access
// point address and frame length limit, then tracked in the station table;
// reads (req_type 1) report one slot. Every item yields one result beat,
// flagged by done for a single cycle, in item order. The receiver cannot stall.
// A two-entry queue sits between the classifier and the table engine; busy is
// high while it is full.
// Tracked frames walk the table memory, one read per cycle, for match, free
// and oldest slot. The engine works on one item at a time: it pops the next
// item from the queue only once it is back in idle after the current item.
// Reset clears all slot valid bits, the accepted counter, and sets the AP
// strength to -99 dBm. Configure through the APB port only while idle:
// offset 0x0 access point address, offset 0x8 maximum frame length.
`timescale 1ns / 1ps
module wireless_client_tracker_top #(
	parameter int CLIENT_SLOTS = wct_pkg::WCT_CLIENT_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wct_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [47:0]                 transmitter_addr,
	input  logic [47:0]                 receiver_addr,
	input  logic signed [7:0]           signal_strength,
	input  logic [11:0]                 frame_length,
	input  logic [31:0]                 now_ms,
	input  logic [4:0]                  read_slot,
	output logic                        done,
	output logic [2:0]                  status,
	output logic [4:0]                  slot,
	output logic [4:0]                  client_count,
	output logic signed [7:0]           ap_strength,
	output logic                        entry_valid,
	output logic [47:0]                 entry_addr,
	output logic signed [7:0]           entry_strength,
	output logic [15:0]                 entry_packets,
	output logic [31:0]                 entry_last_seen,
	output logic [31:0]                 accepted_total
);
	import wct_pkg::*;

	logic  push, pop, full, empty;
	item_t fr_item, hd_item;

	assign pready = 1'b1;
	assign busy   = full;

	wct_front u_front (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.take(start && !full), .req_type, .transmitter_addr, .receiver_addr,
		.signal_strength, .frame_length, .now_ms, .read_slot,
		.push, .item(fr_item)
	);

	wct_fifo u_fifo (
		.clk, .arst_n, .push, .wdata(fr_item), .pop, .rdata(hd_item), .full, .empty
	);

	wct_back #(.CLIENT_SLOTS(CLIENT_SLOTS)) u_back (
		.clk, .arst_n, .q_empty(empty), .q_head(hd_item), .q_pop(pop),
		.done, .status, .slot, .client_count, .ap_strength, .entry_valid,
		.entry_addr, .entry_strength, .entry_packets, .entry_last_seen,
		.accepted_total
	);

endmodule
